@@ rtl/clbp_pkg.sv @@
// shared types and constants for the circular lbp radius-2 code block
package clbp_pkg;

  localparam int CLBP_MAX_WIDTH = 1024;
  localparam int MIN_SIZE       = 5;
  localparam int MAX_HEIGHT     = 4095;
  localparam int BORDER         = 4;

  localparam int PIX_W    = 8;
  localparam int CFG_W_W  = 11;
  localparam int CFG_H_W  = 12;
  localparam int CFG_D_W  = 12;
  localparam int SUM_W    = 24;
  localparam int FIFO_DEP = 8;

  localparam logic [CFG_W_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFG_H_W-1:0] RST_HEIGHT = 12'd480;

  // Q0.16 bilinear weights for the diagonal samples
  localparam logic [15:0] W_NEAR = 16'd22488;
  localparam logic [15:0] W_SIDE = 16'd15902;
  localparam logic [15:0] W_FAR  = 16'd11244;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // 5x5 neighbourhood, [row][col], row 0 oldest
  typedef logic [4:0][4:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic vld;
    logic last;
  } clbp_tag_t;

endpackage

@@ rtl/clbp_ram.sv @@
// generic single-write, single-read synchronous ram with registered read
module clbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/clbp_code.sv @@
// lbp code unit: registered bilinear sums and axis comparisons, then the four diagonal comparisons
module clbp_code
  import clbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  clbp_tag_t  tag_in,
  input  win_t       win,
  output clbp_tag_t  tag_out,
  output logic [7:0] lbp_code
);

  typedef logic [3:0][SUM_W-1:0] sums_t;

  clbp_tag_t        tag_r;
  sums_t            sums_r;
  sums_t            sums_nxt;
  logic [3:0]       axis_r;
  logic [3:0]       axis_nxt;
  logic [SUM_W-1:0] ref_r;

  function automatic logic [SUM_W-1:0] cell_sum(
    input logic [PIX_W-1:0] near,
    input logic [PIX_W-1:0] s1,
    input logic [PIX_W-1:0] s2,
    input logic [PIX_W-1:0] far
  );
    logic [SUM_W-1:0] side;
    side = SUM_W'(s1) + SUM_W'(s2);
    return SUM_W'(near) * SUM_W'(W_NEAR) + side * SUM_W'(W_SIDE)
         + SUM_W'(far) * SUM_W'(W_FAR);
  endfunction

  always_comb begin
    // 0 up-right, 1 up-left, 2 down-left, 3 down-right
    sums_nxt[0] = cell_sum(win[1][3], win[0][3], win[1][4], win[0][4]);
    sums_nxt[1] = cell_sum(win[1][1], win[0][1], win[1][0], win[0][0]);
    sums_nxt[2] = cell_sum(win[3][1], win[3][0], win[4][1], win[4][0]);
    sums_nxt[3] = cell_sum(win[3][3], win[3][4], win[4][3], win[4][4]);
    // 0 right, 1 up, 2 left, 3 down
    axis_nxt[0] = win[2][4] >= win[2][2];
    axis_nxt[1] = win[0][2] >= win[2][2];
    axis_nxt[2] = win[2][0] >= win[2][2];
    axis_nxt[3] = win[4][2] >= win[2][2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else begin
      tag_r.vld <= tag_in.vld;
    end
    tag_r.last <= tag_in.last;
    sums_r     <= sums_nxt;
    axis_r     <= axis_nxt;
    ref_r      <= {win[2][2], 16'd0};
  end

  always_comb begin
    tag_out     = tag_r;
    lbp_code[0] = axis_r[0];
    lbp_code[1] = sums_r[0] >= ref_r;
    lbp_code[2] = axis_r[1];
    lbp_code[3] = sums_r[1] >= ref_r;
    lbp_code[4] = axis_r[2];
    lbp_code[5] = sums_r[2] >= ref_r;
    lbp_code[6] = axis_r[3];
    lbp_code[7] = sums_r[3] >= ref_r;
  end

endmodule

@@ rtl/circular_lbp_radius2_code.sv @@
// top level: line store, 5x5 window, lbp code pipeline and result queue
//
//   channel | handshake              | payload
//   in      | in_valid / in_stall    | in_pixel[7:0], in_frame_start
//   out     | out_valid / out_stall  | out_lbp_code[7:0], out_frame_last
//   cfg     | cfg_valid / cfg_ready  | cfg_index (0 width, 1 height), cfg_data[11:0]
//
// one pixel per cycle while in_stall is low; a code passes the line ram read,
// window shift and sum stage registers after its pixel is taken.
// the line ram holds four rows per column in one word, read and written back
// once per pixel; a write to the column just read is forwarded.
// rst_n is synchronous; it clears counters, pipeline valids and the queue.
// an 8-word result queue absorbs out_stall; in_stall rises once the queue
// plus the words still in the pipeline could fill it.
module circular_lbp_radius2_code
  import clbp_pkg::*;
#(
  parameter int MAX_WIDTH = CLBP_MAX_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   in_pixel,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_lbp_code,
  output logic               out_frame_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfg_reg_t           cfg_index,
  input  logic [CFG_D_W-1:0] cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int LW   = 4 * PIX_W;
  localparam int QA_W = $clog2(FIFO_DEP);
  localparam int QC_W = $clog2(FIFO_DEP + 1);

  // configuration
  logic [CFG_W_W-1:0] cfg_width_r;
  logic [CFG_H_W-1:0] cfg_height_r;
  logic [31:0]        w_ext;
  logic [31:0]        w_clamp;
  logic [31:0]        h_ext;
  logic [31:0]        h_clamp;
  logic [WW-1:0]      w_eff;
  logic [CFG_H_W-1:0] h_eff;

  // position
  logic [CW-1:0]      col_cnt_r;
  logic [CW-1:0]      col_cnt_nxt;
  logic [CFG_H_W-1:0] row_cnt_r;
  logic [CFG_H_W-1:0] row_cnt_nxt;
  logic [CW-1:0]      col_base;
  logic [CW-1:0]      col_cur;
  logic [CFG_H_W-1:0] row_base;
  logic [CFG_H_W-1:0] row_cur;
  logic [WW-1:0]      col_inc;
  logic [CFG_H_W:0]   row_inc;
  logic               pos_emit;
  logic               pos_last;
  logic               accept;

  // line ram stage
  logic               s1_vld_r;
  logic [PIX_W-1:0]   s1_pixel_r;
  logic [CW-1:0]      s1_col_r;
  logic               s1_emit_r;
  logic               s1_last_r;
  logic               fwd_r;
  logic [LW-1:0]      fwd_data_r;
  logic [LW-1:0]      ram_rdata;
  logic [LW-1:0]      line_word;
  logic [LW-1:0]      wr_data;

  // window
  win_t               win_r;
  win_t               win_nxt;
  clbp_tag_t          s2_tag_r;
  clbp_tag_t          code_tag;
  logic [7:0]         code_val;

  // result queue
  logic [8:0]         q_mem_r [FIFO_DEP];
  logic [QA_W-1:0]    q_wp_r;
  logic [QA_W-1:0]    q_rp_r;
  logic [QC_W-1:0]    q_cnt_r;
  logic [QC_W-1:0]    q_cnt_nxt;
  logic [QC_W+1:0]    pending;
  logic               q_push;
  logic               q_pop;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RST_WIDTH;
      cfg_height_r <= RST_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data[CFG_W_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height_r <= cfg_data[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_ext   = 32'(cfg_width_r);
    h_ext   = 32'(cfg_height_r);
    w_clamp = (w_ext < 32'(MIN_SIZE))  ? 32'(MIN_SIZE)  :
              (w_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : w_ext;
    h_clamp = (h_ext < 32'(MIN_SIZE))   ? 32'(MIN_SIZE)   :
              (h_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : h_ext;
    w_eff   = w_clamp[WW-1:0];
    h_eff   = h_clamp[CFG_H_W-1:0];
  end

  // ---------------- position ----------------
  assign accept = in_valid && !in_stall;

  always_comb begin
    col_base = in_frame_start ? '0 : col_cnt_r;
    row_base = in_frame_start ? '0 : row_cnt_r;
    // a limit lowered mid-frame ends the row or frame at once
    col_cur  = (WW'(col_base) >= w_eff) ? '0 : col_base;
    row_cur  = (row_base >= h_eff) ? '0 : row_base;
    col_inc  = WW'(col_cur) + WW'(1);
    row_inc  = (CFG_H_W + 1)'(row_cur) + (CFG_H_W + 1)'(1);
    pos_emit = (32'(row_cur) >= 32'(BORDER)) && (32'(col_cur) >= 32'(BORDER));
    pos_last = (row_inc == {1'b0, h_eff}) && (col_inc == w_eff);
    if (col_inc >= w_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[CFG_H_W-1:0];
    end else begin
      col_cnt_nxt = col_inc[CW-1:0];
      row_cnt_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // ---------------- line ram, read then write back ----------------
  clbp_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_col_r),
    .wdata (wr_data),
    .raddr (col_cur),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
    if (accept) begin
      s1_pixel_r <= in_pixel;
      s1_col_r   <= col_cur;
      s1_emit_r  <= pos_emit;
      s1_last_r  <= pos_last;
      // same column written this cycle: ram read returns stale word
      fwd_r      <= s1_vld_r && (s1_col_r == col_cur);
    end
    fwd_data_r <= wr_data;
  end

  // word byte r is line row r, byte 0 the oldest row
  assign line_word = fwd_r ? fwd_data_r : ram_rdata;
  assign wr_data   = {s1_pixel_r, line_word[LW-1:PIX_W]};

  // ---------------- window ----------------
  always_comb begin
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 4; c++) begin
        win_nxt[r][c] = win_r[r][c+1];
      end
      win_nxt[r][4] = (r < 4) ? line_word[r*PIX_W +: PIX_W] : s1_pixel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r.vld <= 1'b0;
    end else begin
      s2_tag_r.vld <= s1_vld_r && s1_emit_r;
    end
    s2_tag_r.last <= s1_last_r;
    if (s1_vld_r) begin
      win_r <= win_nxt;
    end
  end

  clbp_code u_code (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (s2_tag_r),
    .win      (win_r),
    .tag_out  (code_tag),
    .lbp_code (code_val)
  );

  // ---------------- result queue ----------------
  assign q_push  = code_tag.vld;
  assign q_pop   = out_valid && !out_stall;
  assign pending = (QC_W + 2)'(q_cnt_r) + (QC_W + 2)'(s1_vld_r)
                 + (QC_W + 2)'(s2_tag_r.vld) + (QC_W + 2)'(code_tag.vld);
  assign in_stall = pending >= (QC_W + 2)'(FIFO_DEP);

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (q_push && !q_pop) begin
      q_cnt_nxt = q_cnt_r + QC_W'(1);
    end else if (!q_push && q_pop) begin
      q_cnt_nxt = q_cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (q_push) begin
        q_wp_r <= q_wp_r + QA_W'(1);
      end
      if (q_pop) begin
        q_rp_r <= q_rp_r + QA_W'(1);
      end
    end
    if (q_push) begin
      q_mem_r[q_wp_r] <= {code_tag.last, code_val};
    end
  end

  assign out_valid      = q_cnt_r != '0;
  assign out_lbp_code   = q_mem_r[q_rp_r][7:0];
  assign out_frame_last = q_mem_r[q_rp_r][8];

  // ---------------- checks ----------------
  a_queue_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && !q_pop && (q_cnt_r == QC_W'(FIFO_DEP))))
    else $error("result queue overflow");

  a_credit_bound : assert property (@(posedge clk) disable iff (!rst_n)
    pending <= (QC_W + 2)'(FIFO_DEP))
    else $error("more words in flight than queue space");

  a_frame_start_col : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_frame_start) |=> (s1_col_r == '0 && !s1_emit_r))
    else $error("frame start did not restart position");

  a_emit_reaches_queue : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_emit_r) |=> ##1 q_push)
    else $error("emitted pixel lost between window and queue");

endmodule

@@ dv/circular_lbp_radius2_code_tb.sv @@
// self-checking testbench for the radius-2 circular lbp code block
module circular_lbp_radius2_code_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import clbp_pkg::*;

  localparam int STUCK_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_PIXELS = 400;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pixel_word_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } code_word_t;

  typedef enum int {
    PAT_ZERO, PAT_FULL, PAT_SPIKE, PAT_PIT, PAT_CORNER, PAT_NOISE, PAT_NEAR
  } pattern_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   in_pixel = '0;
  logic               in_frame_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_lbp_code;
  logic               out_frame_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_reg_t           cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_D_W-1:0] cfg_data = '0;

  // predictor state
  logic [CFG_W_W-1:0] width_reg = RST_WIDTH;
  logic [CFG_H_W-1:0] height_reg = RST_HEIGHT;
  logic [7:0]         row_mem [4][CLBP_MAX_WIDTH];
  logic [7:0]         win_buf [5][5];
  int                 col_pos = 0;
  int                 row_pos = 0;

  pixel_word_t pending_pixels [$];
  code_word_t  pending_codes [$];

  bit   in_gaps_on = 1'b0;
  bit   out_stalls_on = 1'b0;
  logic hold_on = 1'b0;
  int   in_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   codes_seen = 0;
  int   errors = 0;
  int   stuck_cycles = 0;

  circular_lbp_radius2_code dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_lbp_code   (out_lbp_code),
    .out_frame_last (out_frame_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int used_size(int raw, int lo, int hi);
    if (raw < lo) return lo;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // weighted sum of one diagonal cell, kept exact in q8.16
  function automatic int unsigned diag_sum(logic [7:0] near_px, logic [7:0] side_a,
                                           logic [7:0] side_b, logic [7:0] far_px);
    return int'(near_px) * W_NEAR + (int'(side_a) + int'(side_b)) * W_SIDE
           + int'(far_px) * W_FAR;
  endfunction

  function automatic void predict_code(logic [7:0] pix, logic fs);
    int          w;
    int          h;
    int          col;
    int          row;
    logic [7:0]  column_bytes [5];
    int unsigned ctr;
    int unsigned ctr_scaled;
    code_word_t  word;
    w = used_size(int'(width_reg), MIN_SIZE, CLBP_MAX_WIDTH);
    h = used_size(int'(height_reg), MIN_SIZE, MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    col = col_pos;
    row = row_pos;
    for (int r = 0; r < 4; r++) column_bytes[r] = row_mem[r][col];
    column_bytes[4] = pix;
    for (int r = 0; r < 4; r++) row_mem[r][col] = column_bytes[r+1];
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 4; c++) win_buf[r][c] = win_buf[r][c+1];
      win_buf[r][4] = column_bytes[r];
    end
    if (row >= BORDER && col >= BORDER) begin
      ctr = win_buf[2][2];
      ctr_scaled = ctr << 16;
      word.code[0] = win_buf[2][4] >= ctr;
      word.code[1] = diag_sum(win_buf[1][3], win_buf[0][3], win_buf[1][4], win_buf[0][4])
                     >= ctr_scaled;
      word.code[2] = win_buf[0][2] >= ctr;
      word.code[3] = diag_sum(win_buf[1][1], win_buf[0][1], win_buf[1][0], win_buf[0][0])
                     >= ctr_scaled;
      word.code[4] = win_buf[2][0] >= ctr;
      word.code[5] = diag_sum(win_buf[3][1], win_buf[3][0], win_buf[4][1], win_buf[4][0])
                     >= ctr_scaled;
      word.code[6] = win_buf[4][2] >= ctr;
      word.code[7] = diag_sum(win_buf[3][3], win_buf[3][4], win_buf[4][3], win_buf[4][4])
                     >= ctr_scaled;
      word.last = (row + 1 == h) && (col + 1 == w);
      pending_codes.push_back(word);
    end
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
  endfunction

  // queue count pixels of a frame w wide, raster order from the top left
  task automatic push_frame(int w, pattern_e pat, bit mark, int count);
    pixel_word_t word;
    int          r;
    int          c;
    for (int i = 0; i < count; i++) begin
      r = i / w;
      c = i % w;
      case (pat)
        PAT_ZERO:   word.pixel = 8'd0;
        PAT_FULL:   word.pixel = 8'd255;
        PAT_SPIKE:  word.pixel = (r == 2 && c == 2) ? 8'd255 : 8'd0;
        PAT_PIT:    word.pixel = (r == 2 && c == 2) ? 8'd0 : 8'd255;
        // corner pixels one below the centre, so each diagonal sum misses a tie by W_FAR
        PAT_CORNER: word.pixel = ((r == 0 || r == 4) && (c == 0 || c == 4)) ? 8'd99 : 8'd100;
        PAT_NEAR:   word.pixel = 8'(127 + $urandom_range(0, 2));
        default:    word.pixel = 8'($urandom_range(0, 255));
      endcase
      word.frame_start = mark && (i == 0);
      pending_pixels.push_back(word);
    end
  endtask

  // wait until every queued pixel is taken and every code has come back
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid || pending_codes.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_D_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_WIDTH) width_reg = val[CFG_W_W-1:0];
    else height_reg = val[CFG_H_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  // input driver
  always @(posedge clk) begin : drive_pixels
    pixel_word_t word;
    int          pick;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_code(in_pixel, in_frame_start);
        pick = $urandom_range(0, 99);
        if (!in_gaps_on || pick < 65) in_gap = 0;
        else if (pick < 93) in_gap = $urandom_range(1, 3);
        else in_gap = $urandom_range(8, 40);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0 && !hold_on) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          word = pending_pixels.pop_front();
          in_valid       <= 1'b1;
          in_pixel       <= word.pixel;
          in_frame_start <= word.frame_start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : take_codes
    code_word_t word;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_on   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_codes.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: code with none expected, got code %02h last %0b",
                     $time, out_lbp_code, out_frame_last);
        end else begin
          word = pending_codes.pop_front();
          if (word.code !== out_lbp_code || word.last !== out_frame_last) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: mismatch, expected code %02h last %0b, got code %02h last %0b",
                       $time, word.code, word.last, out_lbp_code, out_frame_last);
          end
        end
        codes_seen++;
        // long hold-off so the result queue fills and the input backs up
        if (codes_seen % 25 == 20) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
        hold_on   <= 1'b1;
      end else begin
        hold_on <= 1'b0;
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else if (out_stalls_on && $urandom_range(0, 99) < 15) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) - 1
                                                   : $urandom_range(1, 3) - 1;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int          w;
    int          h;
    int          nframes;
    int          count;
    int          random_sent;
    bit          need_mark;
    logic [11:0] raw_w;
    logic [11:0] raw_h;
    pattern_e    pat;
    foreach (row_mem[r, c]) row_mem[r][c] = '0;
    foreach (win_buf[r, c]) win_buf[r][c] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes, no idling: thirty pixels into row zero give no code
    push_frame(640, PAT_NEAR, 1'b1, 30);
    wait_idle();
    // narrowing mid-frame restarts the row at column zero at once
    write_reg(REG_IMAGE_WIDTH, 12'd5);
    push_frame(5, PAT_NOISE, 1'b0, 25);
    wait_idle();
    // row five is past the clamped height, so the frame ends here
    write_reg(REG_IMAGE_HEIGHT, 12'd3);
    push_frame(5, PAT_ZERO, 1'b0, 25);
    push_frame(5, PAT_FULL, 1'b0, 25);
    push_frame(5, PAT_SPIKE, 1'b0, 25);
    push_frame(5, PAT_PIT, 1'b1, 25);
    push_frame(5, PAT_NOISE, 1'b0, 12);
    push_frame(5, PAT_CORNER, 1'b1, 25);
    push_frame(5, PAT_NEAR, 1'b0, 25);
    wait_idle();
    // top data bit falls outside the width register
    write_reg(REG_IMAGE_WIDTH, 12'h805);
    write_reg(REG_IMAGE_HEIGHT, 12'h000);
    push_frame(5, PAT_NOISE, 1'b1, 25);

    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      wait_idle();
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(5, 12);
      h = $urandom_range(5, 9);
      raw_w = (w == 5 && $urandom_range(0, 1)) ? 12'($urandom_range(0, 4)) : 12'(w);
      if ($urandom_range(0, 1)) raw_w[11] = 1'b1;
      raw_h = (h == 5 && $urandom_range(0, 1)) ? 12'($urandom_range(0, 4)) : 12'(h);
      write_reg(REG_IMAGE_WIDTH, raw_w);
      write_reg(REG_IMAGE_HEIGHT, raw_h);
      in_gaps_on    = $urandom_range(0, 3) != 0;
      out_stalls_on = $urandom_range(0, 3) != 0;
      nframes = $urandom_range(1, 3);
      need_mark = 1'b1;
      for (int f = 0; f < nframes; f++) begin
        count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h - 1) : w * h;
        pat = ($urandom_range(0, 1) != 0) ? PAT_NOISE : PAT_NEAR;
        push_frame(w, pat, need_mark || $urandom_range(0, 3) == 0, count);
        need_mark = count != w * h;
        random_sent += count;
      end
    end

    while (pending_pixels.size() != 0 || in_valid || pending_codes.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_codes.size() != 0) begin
      errors++;
      $display("%0t: %0d expected codes never arrived", $time, pending_codes.size());
    end
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
rtl/clbp_pkg.sv
rtl/clbp_ram.sv
rtl/clbp_code.sv
rtl/circular_lbp_radius2_code.sv
dv/circular_lbp_radius2_code_tb.sv
